[rtl/core/ddo_pkg.sv]
// ----------------------------------------------------------------------------
// ddo_pkg
// shared types, constants and tables for the wheel odometry block
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int CORDIC_STEPS_MAX = 32;

    localparam int MUL_DIGITS  = 4;
    localparam int MUL_DIGIT_W = 16;

    localparam int CFG_IDX_W = 2;

    localparam logic [14:0] GLITCH_LIMIT_RST    = 15'd220;
    localparam logic [31:0] METERS_PER_TICK_RST = 32'd4294967;
    localparam logic [31:0] TURN_PER_TICK_RST   = 32'd1048576;
    localparam logic [31:0] INV_PERIOD_RST      = 32'd1310720;

    localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;
    localparam logic [31:0] TWO_PI_Q29  = 32'hC90FDAA2;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS_MAX] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLITCH_LIMIT    = 2'd0,
        CFG_METERS_PER_TICK = 2'd1,
        CFG_TURN_PER_TICK   = 2'd2,
        CFG_INV_PERIOD      = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_DIST = 3'd0,
        OP_DTH  = 3'd1,
        OP_LIN  = 3'd2,
        OP_ANG1 = 3'd3,
        OP_ANG2 = 3'd4,
        OP_X    = 3'd5,
        OP_Y    = 3'd6
    } op_t;

    typedef struct packed {
        logic accept;
        logic cordic_start;
        logic mul_load;
        logic mul_step;
        logic store;
        op_t  op;
        logic out_load;
    } ddo_cmd_t;

    typedef struct packed {
        logic cordic_done;
        logic out_free;
    } ddo_sts_t;

endpackage

[rtl/core/ddo_in_if.sv]
// ----------------------------------------------------------------------------
// ddo_in_if
// input channel: one beat carries both wheel tick deltas
// ----------------------------------------------------------------------------
interface ddo_in_if;

    logic               valid;
    logic               ready;
    logic signed [15:0] left_ticks;
    logic signed [15:0] right_ticks;

    modport source (output valid, output left_ticks, output right_ticks, input ready);
    modport sink   (input valid, input left_ticks, input right_ticks, output ready);

endinterface

[rtl/core/ddo_out_if.sv]
// ----------------------------------------------------------------------------
// ddo_out_if
// output channel: one beat carries pose, speeds and stationary flag
// ----------------------------------------------------------------------------
interface ddo_out_if;

    logic               valid;
    logic               ready;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic        [31:0] heading;
    logic signed [31:0] linear_speed;
    logic signed [31:0] angular_speed;
    logic               stationary;

    modport source (output valid, output x_pos, output y_pos, output heading,
                    output linear_speed, output angular_speed, output stationary,
                    input ready);
    modport sink   (input valid, input x_pos, input y_pos, input heading,
                    input linear_speed, input angular_speed, input stationary,
                    output ready);

endinterface

[rtl/core/diff_drive_odometry.sv]
// ----------------------------------------------------------------------------
// diff_drive_odometry
// sequence: seven products of four 16 bit digits each run in turn on the one
//   shared multiplier while the cordic runs alongside; after the speed products
//   the sequencer waits for the cordic if it is not done, then for a free output
//   register; a new beat is taken only once the last one has been handed on
// reset: pose and heading clear to zero, registers load their defaults,
//   the block takes a beat in the first cycle after reset
// ----------------------------------------------------------------------------
module diff_drive_odometry #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ddo_in_if.sink                        in_ch,
    ddo_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import ddo_pkg::*;

    ddo_cmd_t cmd;
    ddo_sts_t sts;

    ddo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ddo_datapath #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .left_ticks    (in_ch.left_ticks),
        .right_ticks   (in_ch.right_ticks),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .x_pos         (out_ch.x_pos),
        .y_pos         (out_ch.y_pos),
        .heading       (out_ch.heading),
        .linear_speed  (out_ch.linear_speed),
        .angular_speed (out_ch.angular_speed),
        .stationary    (out_ch.stationary)
    );

endmodule

[rtl/core/ddo_mul.sv]
// ----------------------------------------------------------------------------
// ddo_mul
// sequential unsigned multiplier, 64 x 32 bits, one 16 bit digit per cycle
// ----------------------------------------------------------------------------
module ddo_mul (
    input  logic        clk,
    input  logic        load,
    input  logic        step,
    input  logic [63:0] a,
    input  logic [31:0] b,
    output logic [95:0] p
);
    import ddo_pkg::*;

    logic [95:0] acc_reg;
    logic [95:0] acc_next;
    logic [31:0] b_reg;
    logic [47:0] part;

    assign part = 48'(acc_reg[95:64]) + 48'(acc_reg[MUL_DIGIT_W-1:0]) * 48'(b_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (load)
        begin
            acc_next = {32'd0, a};
        end
        else if (step)
        begin
            acc_next = {part, acc_reg[63:MUL_DIGIT_W]};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (load)
        begin
            b_reg <= b;
        end
    end

    assign p = acc_reg;

endmodule

[rtl/core/ddo_cordic.sv]
// ----------------------------------------------------------------------------
// ddo_cordic
// iterative rotation cordic, cosine and sine in signed Q3.30 of a 32 bit binary angle, 2^32 per turn
// ----------------------------------------------------------------------------
module ddo_cordic #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] angle,
    output logic        done,
    output logic [33:0] cos_out,
    output logic [33:0] sin_out
);
    import ddo_pkg::*;

    localparam int CW = $clog2(CORDIC_STEPS + 1);

    logic [33:0]   x_reg, x_next;
    logic [33:0]   y_reg, y_next;
    logic [33:0]   z_reg, z_next;
    logic [1:0]    q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [31:0] a_off;
    logic [31:0] z_fold;
    logic [33:0] x_sh, y_sh, atan_w;

    assign a_off  = angle + 32'h20000000;
    assign z_fold = angle - {a_off[31:30], 30'd0};
    assign x_sh   = $unsigned($signed(x_reg) >>> cnt_reg);
    assign y_sh   = $unsigned($signed(y_reg) >>> cnt_reg);
    assign atan_w = {2'b00, ATAN_TURNS[5'(cnt_reg)]};

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            x_next    = {2'b00, CORDIC_GAIN};
            y_next    = 34'd0;
            z_next    = {{2{z_fold[31]}}, z_fold};
            q_next    = a_off[31:30];
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - atan_w;
            end
            else
            begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + atan_w;
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        q_reg <= q_next;
    end

    // quadrant unfold
    always_comb
    begin
        unique case (q_reg)
            2'd0:
            begin
                cos_out = x_reg;
                sin_out = y_reg;
            end
            2'd1:
            begin
                cos_out = 34'd0 - y_reg;
                sin_out = x_reg;
            end
            2'd2:
            begin
                cos_out = 34'd0 - x_reg;
                sin_out = 34'd0 - y_reg;
            end
            default:
            begin
                cos_out = y_reg;
                sin_out = 34'd0 - x_reg;
            end
        endcase
    end

    assign done = done_reg;

endmodule

[rtl/core/ddo_datapath.sv]
// ----------------------------------------------------------------------------
// ddo_datapath
// config registers, tick filtering, shared multiplier, cordic, pose state
// and the output register
// ----------------------------------------------------------------------------
module ddo_datapath #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ddo_pkg::ddo_cmd_t             cmd,
    output ddo_pkg::ddo_sts_t             sts,
    input  logic                          cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic signed [15:0]            left_ticks,
    input  logic signed [15:0]            right_ticks,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic signed [31:0]            x_pos,
    output logic signed [31:0]            y_pos,
    output logic [31:0]                   heading,
    output logic signed [31:0]            linear_speed,
    output logic signed [31:0]            angular_speed,
    output logic                          stationary
);
    import ddo_pkg::*;

    function automatic logic [31:0] sat_signed(input logic neg, input logic [49:0] v);
        logic [31:0] r;
        if (neg)
        begin
            r = (v > 50'h0_8000_0000) ? 32'h8000_0000 : 32'd0 - v[31:0];
        end
        else
        begin
            r = (v > 50'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
        end
        return r;
    endfunction

    function automatic logic [35:0] round_inc(input logic neg, input logic [63:0] pm);
        logic [65:0] sp;
        logic [65:0] t;
        sp = neg ? 66'd0 - {2'b00, pm} : {2'b00, pm};
        t  = sp + 66'd536870912;
        return t[65:30];
    endfunction

    function automatic logic [31:0] clamp_add(input logic [31:0] pos, input logic [35:0] inc);
        logic [36:0] s;
        logic [31:0] r;
        s = {{5{pos[31]}}, pos} + {inc[35], inc};
        if (!s[36] && (|s[35:31]))
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (s[36] && !(&s[35:31]))
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = s[31:0];
        end
        return r;
    endfunction

    // configuration
    logic [14:0] glitch_reg;
    logic [31:0] mpt_reg, tpt_reg, inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glitch_reg <= GLITCH_LIMIT_RST;
            mpt_reg    <= METERS_PER_TICK_RST;
            tpt_reg    <= TURN_PER_TICK_RST;
            inv_reg    <= INV_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GLITCH_LIMIT:    glitch_reg <= cfg_data[14:0];
                CFG_METERS_PER_TICK: mpt_reg    <= cfg_data;
                CFG_TURN_PER_TICK:   tpt_reg    <= cfg_data;
                CFG_INV_PERIOD:      inv_reg    <= cfg_data;
                default:             glitch_reg <= glitch_reg;
            endcase
        end
    end

    // tick filtering
    logic [16:0] gl_ext, l_ext, r_ext, l_f, r_f, rn;
    logic [17:0] sum_w, diff_w, sum_abs, diff_abs;
    logic        l_bad, r_bad;

    assign gl_ext = {2'b00, glitch_reg};
    assign l_ext  = {left_ticks[15], left_ticks};
    assign r_ext  = {right_ticks[15], right_ticks};
    assign l_bad  = ($signed(l_ext) > $signed(gl_ext)) || ($signed(l_ext) < -$signed(gl_ext));
    assign r_bad  = ($signed(r_ext) > $signed(gl_ext)) || ($signed(r_ext) < -$signed(gl_ext));
    assign l_f    = l_bad ? 17'd0 : l_ext;
    assign r_f    = r_bad ? 17'd0 : r_ext;
    assign rn     = 17'd0 - r_f;
    assign sum_w  = {l_f[16], l_f} + {rn[16], rn};
    assign diff_w = {rn[16], rn} - {l_f[16], l_f};
    assign sum_abs  = sum_w[17] ? 18'd0 - sum_w : sum_w;
    assign diff_abs = diff_w[17] ? 18'd0 - diff_w : diff_w;

    logic [16:0] sum_mag_reg, diff_mag_reg;
    logic        sum_neg_reg, diff_neg_reg, still_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sum_mag_reg  <= sum_abs[16:0];
            sum_neg_reg  <= sum_w[17];
            diff_mag_reg <= diff_abs[16:0];
            diff_neg_reg <= diff_w[17];
            still_reg    <= (l_f == 17'd0) && (rn == 17'd0);
        end
    end

    // pose state
    logic [31:0] pos_x_reg, pos_y_reg, angle_reg;

    // cordic on the heading held before this item
    logic        cordic_done;
    logic [33:0] cos_w, sin_w, c_abs, s_abs;

    ddo_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.cordic_start),
        .angle   (angle_reg),
        .done    (cordic_done),
        .cos_out (cos_w),
        .sin_out (sin_w)
    );

    assign c_abs = cos_w[33] ? 34'd0 - cos_w : cos_w;
    assign s_abs = sin_w[33] ? 34'd0 - sin_w : sin_w;

    // intermediate results
    logic [33:0] dist_reg, dist_abs;
    logic [48:0] dth_mag_reg;
    logic        dth_neg_reg;
    logic [31:0] dth_low_reg;
    logic [31:0] lin_reg, ang_reg, x_res_reg, y_res_reg;
    logic [61:0] ang_lo_reg;
    logic        ang_sat_reg;

    assign dist_abs = dist_reg[33] ? 34'd0 - dist_reg : dist_reg;

    // shared multiplier
    logic [63:0] mul_a;
    logic [31:0] mul_b;
    logic [95:0] mul_p;

    always_comb
    begin
        unique case (cmd.op)
            OP_DIST:
            begin
                mul_a = {47'd0, sum_mag_reg};
                mul_b = mpt_reg;
            end
            OP_DTH:
            begin
                mul_a = {47'd0, diff_mag_reg};
                mul_b = tpt_reg;
            end
            OP_LIN:
            begin
                mul_a = {31'd0, dist_abs[32:0]};
                mul_b = inv_reg;
            end
            OP_ANG1:
            begin
                mul_a = {15'd0, dth_mag_reg};
                mul_b = inv_reg;
            end
            OP_ANG2:
            begin
                mul_a = {2'd0, ang_lo_reg};
                mul_b = TWO_PI_Q29;
            end
            OP_X:
            begin
                mul_a = {31'd0, dist_abs[32:0]};
                mul_b = c_abs[31:0];
            end
            OP_Y:
            begin
                mul_a = {31'd0, dist_abs[32:0]};
                mul_b = s_abs[31:0];
            end
            default:
            begin
                mul_a = 64'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    ddo_mul u_mul (
        .clk  (clk),
        .load (cmd.mul_load),
        .step (cmd.mul_step),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    // post-processing of the finished product
    logic [50:0] dist_sp, dist_t;
    logic [48:0] dth_pm;
    logic [65:0] lin_t;
    logic [33:0] ang_v;

    assign dist_sp = sum_neg_reg ? 51'd0 - {2'b00, mul_p[48:0]} : {2'b00, mul_p[48:0]};
    assign dist_t  = dist_sp + 51'd65536;
    assign dth_pm  = mul_p[48:0];
    assign lin_t   = {1'b0, mul_p[64:0]} + 66'd32768;
    assign ang_v   = ang_sat_reg ? 34'h1_0000_0000
                                 : {1'b0, mul_p[93:61]} + {33'd0, mul_p[60]};

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            unique case (cmd.op)
                OP_DIST: dist_reg <= dist_t[50:17];
                OP_DTH:
                begin
                    dth_mag_reg <= dth_pm;
                    dth_neg_reg <= diff_neg_reg;
                    dth_low_reg <= diff_neg_reg ? 32'd0 - dth_pm[31:0] : dth_pm[31:0];
                end
                OP_LIN: lin_reg <= sat_signed(dist_reg[33], lin_t[65:16]);
                OP_ANG1:
                begin
                    ang_sat_reg <= |mul_p[95:62];
                    ang_lo_reg  <= mul_p[61:0];
                end
                OP_ANG2: ang_reg <= sat_signed(dth_neg_reg, {16'd0, ang_v});
                OP_X: x_res_reg <= clamp_add(pos_x_reg,
                                             round_inc(dist_reg[33] ^ cos_w[33], mul_p[63:0]));
                OP_Y: y_res_reg <= clamp_add(pos_y_reg,
                                             round_inc(dist_reg[33] ^ sin_w[33], mul_p[63:0]));
                default: dist_reg <= dist_reg;
            endcase
        end
    end

    // pose commit and output register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= 32'd0;
            pos_y_reg     <= 32'd0;
            angle_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                pos_x_reg     <= x_res_reg;
                pos_y_reg     <= y_res_reg;
                angle_reg     <= angle_reg + dth_low_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            x_pos         <= x_res_reg;
            y_pos         <= y_res_reg;
            heading       <= angle_reg + dth_low_reg;
            linear_speed  <= lin_reg;
            angular_speed <= ang_reg;
            stationary    <= still_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign sts.cordic_done = cordic_done;
    assign sts.out_free    = !out_valid_reg || out_ready;

endmodule

[rtl/core/ddo_ctrl.sv]
// ----------------------------------------------------------------------------
// ddo_ctrl
// sequencer: runs the product list through the shared multiplier and
// hands the finished beat to the output register
// ----------------------------------------------------------------------------
module ddo_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ddo_pkg::ddo_sts_t sts,
    output ddo_pkg::ddo_cmd_t cmd
);
    import ddo_pkg::*;

    localparam int CNT_W = $clog2(MUL_DIGITS);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOAD  = 6'b000010,
        ST_STEP  = 6'b000100,
        ST_STORE = 6'b001000,
        ST_WAIT  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.accept       = 1'b1;
                    cmd.cordic_start = 1'b1;
                    op_next          = OP_DIST;
                    state_next       = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.mul_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MUL_DIGITS - 1))
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (op_reg == OP_Y)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    op_next = op_t'(op_reg + 3'd1);
                    if (op_reg == OP_ANG2 && !sts.cordic_done)
                    begin
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_WAIT:
            begin
                if (sts.cordic_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_DIST;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[dv/odometry_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// odometry_checker
// watches the tick and pose channels and the register port, predicts each
// pose beat from the accepted tick beats and compares it field by field
// ----------------------------------------------------------------------------
module odometry_checker #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ddo_in_if           in_ch,
    ddo_out_if          out_ch,
    input  logic        cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          poses_pending
);
    import ddo_pkg::*;

    typedef struct {
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic        [31:0] heading;
        logic signed [31:0] linear_speed;
        logic signed [31:0] angular_speed;
        logic               stationary;
    } pose_t;

    pose_t       pose_q[$];
    logic [14:0] glitch_lim;
    logic [31:0] m_per_tick;
    logic [31:0] t_per_tick;
    logic [31:0] inv_per;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic [31:0] acc_heading;

    assign poses_pending = pose_q.size();

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic cos_sin(input logic [31:0] a, output longint c, output longint s);
        logic [1:0]  q;
        logic [31:0] zu;
        longint      z;
        longint      x;
        longint      y;
        longint      nx;
        q  = 2'((a + 32'h20000000) >> 30);
        zu = a - ({30'd0, q} << 30);
        z  = longint'(zu);
        if (z >= 64'sh80000000)
            z -= 64'sh100000000;
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < CORDIC_STEPS_MAX; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(ATAN_TURNS[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(ATAN_TURNS[i]);
            end
            x = nx;
        end
        case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    task automatic advance_pose(input logic signed [15:0] lt, input logic signed [15:0] rt,
                                output pose_t p);
        int          l;
        int          r;
        int          gl;
        longint      travel;
        longint      dth;
        longint      c;
        longint      s;
        logic [63:0] mag;
        logic [63:0] v;
        logic [127:0] prod;
        logic [127:0] prod2;
        l  = lt;
        r  = rt;
        gl = int'(glitch_lim);
        if (l > gl || l < -gl)
            l = 0;
        if (r > gl || r < -gl)
            r = 0;
        r = -r;
        travel = (longint'(l + r) * longint'(m_per_tick) + 65536) >>> 17;
        dth    = longint'(r - l) * longint'(t_per_tick);
        cos_sin(acc_heading, c, s);
        acc_x = sat32(longint'(acc_x) + ((travel * c + 64'sh20000000) >>> 30));
        acc_y = sat32(longint'(acc_y) + ((travel * s + 64'sh20000000) >>> 30));
        acc_heading = acc_heading + dth[31:0];
        mag = (travel < 0) ? -travel : travel;
        v   = (mag * {32'd0, inv_per} + 64'd32768) >> 16;
        p.linear_speed = sat32((travel < 0) ? -longint'(v) : longint'(v));
        mag  = (dth < 0) ? -dth : dth;
        prod = {64'd0, mag} * {96'd0, inv_per};
        if (prod[127:64] != 0 || prod[63:0] >= (64'd1 << 62))
            v = 64'd1 << 32;
        else
        begin
            prod2 = {64'd0, prod[63:0]} * {96'd0, TWO_PI_Q29};
            v = prod2[124:61] + {63'd0, prod2[60]};
        end
        p.angular_speed = sat32((dth < 0) ? -longint'(v) : longint'(v));
        p.x_pos      = acc_x;
        p.y_pos      = acc_y;
        p.heading    = acc_heading;
        p.stationary = (l == 0 && r == 0);
    endtask

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $time, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pose_t p;
        if (!rst_n)
        begin
            glitch_lim  <= GLITCH_LIMIT_RST;
            m_per_tick  <= METERS_PER_TICK_RST;
            t_per_tick  <= TURN_PER_TICK_RST;
            inv_per     <= INV_PERIOD_RST;
            acc_x       = 0;
            acc_y       = 0;
            acc_heading = 0;
            fail_count  = 0;
            pose_q.delete();
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pose_q.size() == 0)
                begin
                    $display("%0t pose beat with nothing pending", $time);
                    fail_count++;
                end
                else
                begin
                    p = pose_q.pop_front();
                    if (out_ch.x_pos !== p.x_pos)
                        report("x_pos", out_ch.x_pos, p.x_pos);
                    if (out_ch.y_pos !== p.y_pos)
                        report("y_pos", out_ch.y_pos, p.y_pos);
                    if (out_ch.heading !== p.heading)
                        report("heading", out_ch.heading, p.heading);
                    if (out_ch.linear_speed !== p.linear_speed)
                        report("linear_speed", out_ch.linear_speed, p.linear_speed);
                    if (out_ch.angular_speed !== p.angular_speed)
                        report("angular_speed", out_ch.angular_speed, p.angular_speed);
                    if (out_ch.stationary !== p.stationary)
                        report("stationary", {31'd0, out_ch.stationary}, {31'd0, p.stationary});
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                advance_pose(in_ch.left_ticks, in_ch.right_ticks, p);
                pose_q.push_back(p);
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_GLITCH_LIMIT:    glitch_lim <= cfg_data[14:0];
                    CFG_METERS_PER_TICK: m_per_tick <= cfg_data;
                    CFG_TURN_PER_TICK:   t_per_tick <= cfg_data;
                    CFG_INV_PERIOD:      inv_per    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// wheel odometry testbench: directed tick pairs around the glitch limit and
// the field extremes, then random tick pairs under several register settings,
// with random idling on both channels; checking is done by odometry_checker
// ----------------------------------------------------------------------------
module tb;
    import ddo_pkg::*;

    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 5000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;
    logic        calm;
    int          fail_count;
    int          poses_pending;
    int          stall_cycles;
    int          cur_glitch;

    ddo_in_if  in_ch();
    ddo_out_if out_ch();

    diff_drive_odometry i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    odometry_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .poses_pending (poses_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_ch.ready <= calm || ($urandom_range(99) >= 23);

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_ticks(input logic signed [15:0] lt, input logic signed [15:0] rt);
        while (!calm && $urandom_range(99) < 23)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.left_ticks  <= lt;
        in_ch.right_ticks <= rt;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic settle;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (poses_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [14:0] gl, input logic [31:0] mpt,
                              input logic [31:0] tpt, input logic [31:0] inv);
        logic [31:0] vals [4];
        vals = '{{17'd0, gl}, mpt, tpt, inv};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cur_glitch = gl;
    endtask

    task automatic directed_set;
        send_ticks(0, 0);
        send_ticks(16'(cur_glitch), 16'(-cur_glitch));
        send_ticks(16'(cur_glitch + 1), 0);
        send_ticks(0, 16'(-cur_glitch - 1));
        send_ticks(16'sh7FFF, 16'sh8000);
        send_ticks(16'sh8000, 16'sh7FFF);
        send_ticks(100, 100);
        send_ticks(100, -100);
        send_ticks(-100, 100);
        send_ticks(-50, -50);
        send_ticks(16'shFFFF, 16'sh0001);
        send_ticks(16'sh5555, 16'shAAAA);
    endtask

    task automatic random_run(input int n);
        int lim;
        logic signed [15:0] lt;
        logic signed [15:0] rt;
        for (int k = 0; k < n; k++)
        begin
            calm = (k >= n / 3 && k < n / 2);
            lim  = cur_glitch;
            if ($urandom_range(99) < 75)
            begin
                lt = 16'($signed($urandom_range(2 * lim)) - lim);
                rt = 16'($signed($urandom_range(2 * lim)) - lim);
            end
            else
            begin
                lt = 16'($urandom);
                rt = 16'($urandom);
            end
            send_ticks(lt, rt);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        calm             = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.left_ticks = '0;
        in_ch.right_ticks = '0;
        cur_glitch       = GLITCH_LIMIT_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_set();
        random_run(120);
        settle();

        write_regs(15'h7FFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        directed_set();
        random_run(60);
        settle();

        write_regs(15'd0, 32'd0, 32'd0, 32'd0);
        send_ticks(0, 0);
        send_ticks(1, -1);
        random_run(20);
        settle();

        write_regs(15'd1000, 32'd4294967, 32'h01000000, 32'd65536);
        random_run(120);
        settle();

        for (int ph = 0; ph < 3; ph++)
        begin
            write_regs(15'($urandom), $urandom, $urandom, $urandom_range(32'h00200000));
            random_run(60);
            settle();
        end

        write_regs(15'd220, 32'h80000000, 32'h00100000, 32'h00140000);
        random_run(40);
        settle();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
rtl/core/ddo_pkg.sv
rtl/core/ddo_in_if.sv
rtl/core/ddo_out_if.sv
rtl/core/ddo_mul.sv
rtl/core/ddo_cordic.sv
rtl/core/ddo_datapath.sv
rtl/core/ddo_ctrl.sv
rtl/core/diff_drive_odometry.sv
dv/odometry_checker.sv
dv/tb.sv
